/* hdl/pmfd_pkg.sv */
// package for the power meter frame decoder
// frame layout constants, status codes, state types and the muldiv request
package pmfd_pkg;

    localparam int FrameLength = 24;
    localparam int PosWidth    = 5;
    // bytes 2 to 22 go through the payload shift line
    localparam int PayloadBits = (FrameLength - 3) * 8;

    localparam logic [7:0] HeadA     = 8'h55;
    localparam logic [7:0] HeadMin   = 8'hF0;
    localparam logic [7:0] HeadB     = 8'h5A;
    localparam logic [7:0] UncalHead = 8'hAA;
    localparam logic [7:0] FaultMask = 8'hFC;
    localparam logic [7:0] FaultRef  = 8'hF0;
    localparam logic [7:0] PwrMask   = 8'hF2;
    localparam logic [7:0] AdjVolt   = 8'h40;
    localparam logic [7:0] AdjPwr    = 8'h10;
    localparam logic [7:0] AdjCurr   = 8'h20;

    localparam logic [23:0] EnergyDiv  = 24'd1000000;
    localparam logic [55:0] EnergyRnd  = 56'd500000;
    localparam logic [47:0] EnergyMax  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] GainReset  = 32'h0001_0000;

    localparam logic [1:0] CfgVoltGain = 2'd0;
    localparam logic [1:0] CfgCurrGain = 2'd1;
    localparam logic [1:0] CfgPwrGain  = 2'd2;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatCsum  = 2'd1;
    localparam logic [1:0] StatUncal = 2'd2;
    localparam logic [1:0] StatFault = 2'd3;

    localparam int MulSteps = 24;
    localparam int DivSteps = 56;

    typedef enum logic [3:0] {
        ST_RECV, ST_P, ST_PW, ST_V, ST_VW, ST_C, ST_CW, ST_E, ST_EW
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE, MD_MUL, MD_DIV
    } t_md_phase;

    typedef struct packed {
        logic [31:0] a;
        logic [23:0] b;
        logic [23:0] d;
        logic        rnd;
    } t_md_req;

endpackage

/* hdl/pmfd_muldiv.sv */
// bit-serial multiply then restoring divide: floor((a*b + EnergyRnd if rnd) / d)
// uses pmfd_pkg for the request struct and phase type
module pmfd_muldiv
    import pmfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_md_req     i_req,
    output logic        o_done,
    output logic [55:0] o_quot
);

    t_md_phase   r_phase, n_phase;
    logic [5:0]  r_cnt;
    logic [55:0] r_acc;
    logic [55:0] r_mc;
    logic [23:0] r_mp;
    logic [23:0] r_d;
    logic [23:0] r_rem;
    logic        r_done;
    logic [24:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_acc[55]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            MD_IDLE: if (i_start) n_phase = MD_MUL;
            MD_MUL:  if (r_cnt == 6'(MulSteps - 1)) n_phase = MD_DIV;
            MD_DIV:  if (r_cnt == 6'(DivSteps - 1)) n_phase = MD_IDLE;
            default: n_phase = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == MD_DIV) && (r_cnt == 6'(DivSteps - 1));
            if (r_phase != n_phase) r_cnt <= '0;
            else if (r_phase != MD_IDLE) r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            MD_IDLE: begin
                if (i_start) begin
                    r_acc <= i_req.rnd ? EnergyRnd : '0;
                    r_mc  <= {24'd0, i_req.a};
                    r_mp  <= i_req.b;
                    r_d   <= i_req.d;
                    r_rem <= '0;
                end
            end
            MD_MUL: begin
                if (r_mp[0]) r_acc <= r_acc + r_mc;
                r_mc <= {r_mc[54:0], 1'b0};
                r_mp <= {1'b0, r_mp[23:1]};
            end
            MD_DIV: begin
                // one quotient bit a cycle, shifted in behind the dividend
                r_rem <= w_ge ? 24'(w_trial - {1'b0, r_d}) : w_trial[23:0];
                r_acc <= {r_acc[54:0], w_ge};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

/* hdl/power_meter_frame_decoder.sv */
// top level of the power meter frame decoder: framing, status, sequencing
// depends on pmfd_pkg and pmfd_muldiv
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-------------------------------------------
//  rx in    | i_valid | o_ready | i_rx_byte, i_idle_gap
//  result   | o_valid | i_ready | o_status, o_voltage, o_current,
//           |         |         | o_active_power, o_energy_total
//  config   | i_cfg_we| -       | i_cfg_idx, i_cfg_data
//
// a byte is taken on i_valid and o_ready; a frame with an error gives its item at once
// a good frame runs up to four passes of the shared muldiv unit, each
// a bit-serial multiply followed by a restoring divide
// reset is synchronous and clears framing, energy, pulse and held values
// the final byte of a frame waits while the previous item is still held
module power_meter_frame_decoder
    import pmfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_idle_gap,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [55:0] o_voltage,
    output logic [55:0] o_current,
    output logic [55:0] o_active_power,
    output logic [47:0] o_energy_total,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int LastPos = FrameLength - 1;

    t_state r_state, n_state;
    logic [PosWidth-1:0]    r_pos;
    logic [PosWidth-1:0]    w_pos;
    logic [PayloadBits-1:0] r_pay;
    logic [7:0]  r_b0;
    logic [7:0]  r_sum;
    logic [31:0] r_vgain, r_cgain, r_pgain;
    logic [15:0] r_last;
    logic [47:0] r_energy;
    logic [55:0] r_hv, r_hc, r_hp;
    logic [1:0]  r_status;
    logic        r_ovalid;

    logic        w_acc, w_drop, w_store, w_done_frame;
    logic [1:0]  w_stat;
    logic        w_start;
    t_md_req     w_req;
    logic        w_md_done;
    logic [55:0] w_quot;
    logic [23:0] w_cv, w_pv, w_cc, w_pc, w_cp, w_pp;
    logic [7:0]  w_adj;
    logic [15:0] w_pulses, w_delta;
    logic [47:0] w_add;
    logic        w_en_p, w_en_v, w_en_c;

    // byte k of the frame sits at bits (22-k)*8 of the shift line
    assign w_cv     = r_pay[167:144];
    assign w_pv     = r_pay[143:120];
    assign w_cc     = r_pay[119:96];
    assign w_pc     = r_pay[95:72];
    assign w_cp     = r_pay[71:48];
    assign w_pp     = r_pay[47:24];
    assign w_adj    = r_pay[23:16];
    assign w_pulses = r_pay[15:0];
    assign w_delta  = (r_last == 16'd0) ? 16'd0 : (w_pulses - r_last);
    assign w_add    = w_quot[47:0];

    assign w_en_p = ((w_adj & AdjPwr) != 8'd0) && ((r_b0 & PwrMask) != PwrMask)
                    && (w_pp != 24'd0);
    assign w_en_v = ((w_adj & AdjVolt) != 8'd0) && (w_pv != 24'd0);
    assign w_en_c = ((w_adj & AdjCurr) != 8'd0) && (r_hp != 56'd0) && (w_pc != 24'd0);

    assign o_ready = (r_state == ST_RECV) && !(r_ovalid && (r_pos == PosWidth'(LastPos)));
    assign w_acc   = i_valid && o_ready;
    assign w_pos   = i_idle_gap ? '0 : r_pos;
    assign w_drop  = ((w_pos == '0) && (i_rx_byte != HeadA) && (i_rx_byte < HeadMin))
                   || ((w_pos == PosWidth'(1)) && (i_rx_byte != HeadB));
    assign w_store = w_acc && !w_drop;
    assign w_done_frame = w_store && (w_pos == PosWidth'(LastPos));

    always_comb begin
        priority if ((r_sum + 8'd0) != i_rx_byte) w_stat = StatCsum;
        else if (r_b0 == UncalHead)                w_stat = StatUncal;
        else if ((r_b0 & FaultMask) > FaultRef)    w_stat = StatFault;
        else                                       w_stat = StatOk;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RECV: if (w_done_frame && (w_stat == StatOk)) n_state = ST_P;
            ST_P:    n_state = w_en_p ? ST_PW : ST_V;
            ST_PW:   if (w_md_done) n_state = ST_V;
            ST_V:    n_state = w_en_v ? ST_VW : ST_C;
            ST_VW:   if (w_md_done) n_state = ST_C;
            ST_C:    n_state = w_en_c ? ST_CW : ST_E;
            ST_CW:   if (w_md_done) n_state = ST_E;
            ST_E:    n_state = ST_EW;
            ST_EW:   if (w_md_done) n_state = ST_RECV;
            default: n_state = ST_RECV;
        endcase
    end

    // outputs to the muldiv unit
    always_comb begin
        w_start = 1'b0;
        w_req   = '{a: r_pgain, b: w_cp, d: w_pp, rnd: 1'b0};
        unique case (r_state)
            ST_P: w_start = w_en_p;
            ST_V: begin
                w_start = w_en_v;
                w_req   = '{a: r_vgain, b: w_cv, d: w_pv, rnd: 1'b0};
            end
            ST_C: begin
                w_start = w_en_c;
                w_req   = '{a: r_cgain, b: w_cc, d: w_pc, rnd: 1'b0};
            end
            ST_E: begin
                w_start = 1'b1;
                w_req   = '{a: {16'd0, w_delta}, b: w_cp, d: EnergyDiv, rnd: 1'b1};
            end
            default: ;
        endcase
    end

    pmfd_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_md_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RECV;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
            r_status <= StatOk;
            r_last   <= '0;
            r_energy <= '0;
            r_hv     <= '0;
            r_hc     <= '0;
            r_hp     <= '0;
            r_vgain  <= GainReset;
            r_cgain  <= GainReset;
            r_pgain  <= GainReset;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgVoltGain: r_vgain <= i_cfg_data;
                    CfgCurrGain: r_cgain <= i_cfg_data;
                    CfgPwrGain:  r_pgain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (w_acc) begin
                if (w_drop) r_pos <= '0;
                else if (w_done_frame) r_pos <= '0;
                else r_pos <= w_pos + PosWidth'(1);
            end
            if (w_done_frame && (w_stat != StatOk)) begin
                r_status <= w_stat;
                r_ovalid <= 1'b1;
            end
            unique case (r_state)
                ST_P:  if (!w_en_p) r_hp <= '0;
                ST_PW: if (w_md_done) r_hp <= w_quot;
                ST_V:  if (!w_en_v) r_hv <= '0;
                ST_VW: if (w_md_done) r_hv <= w_quot;
                ST_C:  if (!w_en_c) r_hc <= '0;
                ST_CW: if (w_md_done) r_hc <= w_quot;
                ST_EW: begin
                    if (w_md_done) begin
                        r_energy <= (w_add > (EnergyMax - r_energy)) ? EnergyMax
                                                                     : r_energy + w_add;
                        r_last   <= w_pulses;
                        r_status <= StatOk;
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // frame bytes: header byte, running checksum, payload shift line
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            if (w_pos == '0) r_b0 <= i_rx_byte;
            if (w_pos == PosWidth'(2)) r_sum <= i_rx_byte;
            else if (w_pos != PosWidth'(LastPos)) r_sum <= r_sum + i_rx_byte;
            if ((w_pos >= PosWidth'(2)) && (w_pos != PosWidth'(LastPos)))
                r_pay <= {r_pay[PayloadBits-9:0], i_rx_byte};
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_voltage      = r_hv;
    assign o_current      = r_hc;
    assign o_active_power = r_hp;
    assign o_energy_total = r_energy;

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RECV) |-> !o_ready)
        else $error("byte taken while a frame is being computed");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == ST_PW || r_state == ST_VW || r_state == ST_CW
                       || r_state == ST_EW))
        else $error("muldiv finished outside a wait state");
    a_item_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_RECV || $past(r_state) == ST_EW))
        else $error("item raised from an unexpected state");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("pending item dropped");

endmodule

/* dv/testbench.sv */
// testbench for power_meter_frame_decoder: framing, checksum, fault, gating, energy
// depends on pmfd_pkg and the decoder rtl; predicts each frame result and checks it
`timescale 1ns / 100ps

module testbench;
    import pmfd_pkg::*;

    typedef struct {
        logic [7:0] rx_byte;
        logic       idle_gap;
    } t_rx_item;

    typedef struct {
        logic [1:0]  status;
        logic [55:0] voltage;
        logic [55:0] current;
        logic [55:0] active_power;
        logic [47:0] energy_total;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        i_idle_gap = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [55:0] o_voltage;
    logic [55:0] o_current;
    logic [55:0] o_active_power;
    logic [47:0] o_energy_total;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    power_meter_frame_decoder u_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] gain_v, gain_c, gain_p;
    logic [4:0]  frame_pos;
    logic [7:0]  frame_buf [FrameLength];
    logic [15:0] prev_pulses;
    logic [47:0] energy_sum;
    logic [55:0] hold_v, hold_c, hold_p;

    t_rx_item      rx_pending[$];
    t_frame_result results_due[$];
    int            mismatches = 0;
    bit            stall_long = 1'b0;
    bit            rx_taken = 1'b0;

    function automatic logic [23:0] coef_at(int at);
        return {frame_buf[at], frame_buf[at+1], frame_buf[at+2]};
    endfunction

    function automatic logic [55:0] scale_by(logic [31:0] gain, logic [23:0] coef,
                                             logic [23:0] period);
        logic [63:0] prod;
        if (period == 0) return '0;
        prod = 64'(gain) * 64'(coef);
        return 56'(prod / 64'(period));
    endfunction

    function automatic void decode_frame_into_result();
        t_frame_result r;
        logic [7:0]  csum;
        logic [7:0]  adj;
        logic [55:0] v, p, c;
        logic [15:0] pulses, delta;
        logic [63:0] add;
        csum = '0;
        for (int i = 2; i < 23; i++) csum += frame_buf[i];
        if (csum != frame_buf[23]) r.status = StatCsum;
        else if (frame_buf[0] == UncalHead) r.status = StatUncal;
        else if ((frame_buf[0] & FaultMask) > FaultRef) r.status = StatFault;
        else begin
            r.status = StatOk;
            adj = frame_buf[20];
            v = '0; p = '0; c = '0;
            if (adj & AdjVolt) v = scale_by(gain_v, coef_at(2), coef_at(5));
            if ((adj & AdjPwr) && ((frame_buf[0] & PwrMask) != PwrMask))
                p = scale_by(gain_p, coef_at(14), coef_at(17));
            if ((adj & AdjCurr) && p != 0) c = scale_by(gain_c, coef_at(8), coef_at(11));
            pulses = {frame_buf[21], frame_buf[22]};
            if (prev_pulses == 0) prev_pulses = pulses;
            delta = pulses - prev_pulses;
            add = (64'(delta) * 64'(coef_at(14)) + 64'd500000) / 64'd1000000;
            if (add > 64'(EnergyMax - energy_sum)) energy_sum = EnergyMax;
            else energy_sum += 48'(add);
            prev_pulses = pulses;
            hold_v = v; hold_c = c; hold_p = p;
        end
        r.voltage = hold_v;
        r.current = hold_c;
        r.active_power = hold_p;
        r.energy_total = energy_sum;
        results_due.push_back(r);
    endfunction

    function automatic void predict_byte(t_rx_item it);
        if (it.idle_gap) frame_pos = 0;
        if (frame_pos == 0) begin
            if (it.rx_byte != HeadA && it.rx_byte < HeadMin) return;
        end else if (frame_pos == 1) begin
            if (it.rx_byte != HeadB) begin
                frame_pos = 0;
                return;
            end
        end
        frame_buf[frame_pos] = it.rx_byte;
        frame_pos++;
        if (frame_pos < FrameLength) return;
        frame_pos = 0;
        decode_frame_into_result();
    endfunction

    // driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        t_rx_item it;
        if (i_valid && !rx_taken) begin
            // hold
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
            it = rx_pending.pop_front();
            i_rx_byte <= it.rx_byte;
            i_idle_gap <= it.idle_gap;
            i_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                        ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 4);
        end else i_valid <= 1'b0;
    end

    // predictor runs on accepted items
    always @(posedge i_clk) begin
        rx_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) predict_byte('{i_rx_byte, i_idle_gap});
    end

    // receiver idling
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (stall_long) i_ready <= 1'b0;
        else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) < 2)
                recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                        : $urandom_range(1, 4);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frame_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", o_status);
            end else begin
                e = results_due.pop_front();
                if (o_status !== e.status || o_voltage !== e.voltage ||
                    o_current !== e.current || o_active_power !== e.active_power ||
                    o_energy_total !== e.energy_total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d v=%h c=%h p=%h e=%h got st=%0d v=%h c=%h p=%h e=%h",
                                 e.status, e.voltage, e.current, e.active_power,
                                 e.energy_total, o_status, o_voltage, o_current,
                                 o_active_power, o_energy_total);
                end
            end
        end
    end

    // frame builders
    task automatic push_byte(logic [7:0] b, logic g = 1'b0);
        rx_pending.push_back('{b, g});
    endtask

    task automatic push_frame(logic [7:0] head, logic [7:0] adj, logic [15:0] pulses,
                              bit bad_sum, int mode);
        logic [7:0] f [FrameLength];
        logic [7:0] s;
        f[0] = head; f[1] = HeadB;
        for (int i = 2; i < 20; i++) begin
            case (mode)
                0: f[i] = 8'($urandom);
                1: f[i] = 8'hFF;
                2: f[i] = ((i - 2) % 3 == 0) ? 8'h00 : 8'($urandom);
                default: f[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            endcase
        end
        if (mode == 1) begin
            f[5] = 0; f[6] = 0; f[7] = 1; f[17] = 0; f[18] = 0; f[19] = 1;
            f[11] = 0; f[12] = 0; f[13] = 1;
        end
        if (mode == 3) begin
            f[5] = 0; f[6] = 0; f[7] = 0;
        end
        f[20] = adj; f[21] = pulses[15:8]; f[22] = pulses[7:0];
        s = '0;
        for (int i = 2; i < 23; i++) s += f[i];
        f[23] = bad_sum ? s ^ 8'(1 << $urandom_range(0, 7)) : s;
        for (int i = 0; i < FrameLength; i++)
            push_byte(f[i], (i == 0) ? 1'b1 : 1'b0);
    endtask

    function automatic logic [7:0] pick_head();
        case ($urandom_range(0, 5))
            0, 1, 2: return HeadA;
            3: return 8'hF0 | 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(8'hF0, 8'hFF));
        endcase
    endfunction

    task automatic wait_drain();
        while (rx_pending.size() > 0 || i_valid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        case (idx)
            CfgVoltGain: gain_v = val;
            CfgCurrGain: gain_c = val;
            default:     gain_p = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int frames;
        logic [15:0] pc;
        frames = 0;
        pc = 16'($urandom);
        while (frames < n) begin
            case ($urandom_range(0, 19))
                0: push_byte(8'($urandom), 1'($urandom));
                1: begin
                    push_byte(pick_head(), 1'b1);
                    push_byte(8'($urandom));
                end
                2: begin
                    // broken frame, restarted by idle gap
                    push_byte(HeadA, 1'b1); push_byte(HeadB);
                    repeat ($urandom_range(1, 20)) push_byte(8'($urandom));
                end
                default: begin
                    pc += ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
                    push_frame(pick_head(), 8'($urandom),
                               ($urandom_range(0, 30) == 0) ? 16'h0 : pc,
                               $urandom_range(0, 7) == 0, $urandom_range(0, 3));
                    frames++;
                end
            endcase
        end
    endtask

    initial begin
        gain_v = GainReset; gain_c = GainReset; gain_p = GainReset;
        frame_pos = 0; prev_pulses = 0; energy_sum = 0;
        hold_v = 0; hold_c = 0; hold_p = 0;
        for (int i = 0; i < FrameLength; i++) frame_buf[i] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: header rules, gating, status codes, pulse wrap, extremes
        push_byte(8'h00); push_byte(8'hAA); push_byte(HeadA); push_byte(8'h00);
        push_frame(HeadA, 8'h70, 16'h0010, 0, 1);
        push_frame(HeadA, 8'h70, 16'hFFF0, 0, 1);
        push_frame(HeadA, 8'h70, 16'h0005, 0, 1);
        push_frame(8'hF2, 8'h70, 16'h0100, 0, 0);
        push_frame(8'hF4, 8'hFF, 16'h0200, 0, 0);
        push_frame(HeadA, 8'hFF, 16'h0300, 1, 0);
        push_frame(8'hFF, 8'hFF, 16'h0400, 0, 0);
        push_frame(HeadA, 8'h20, 16'h0500, 0, 3);
        push_frame(HeadA, 8'h00, 16'h0600, 0, 2);
        wait_drain();

        write_gain(CfgVoltGain, 32'hFFFF_FFFF);
        write_gain(CfgCurrGain, 32'hFFFF_FFFF);
        write_gain(CfgPwrGain, 32'hFFFF_FFFF);
        push_frame(HeadA, 8'h70, 16'hFFFF, 0, 1);
        push_frame(HeadA, 8'h70, 16'h7FFF, 0, 0);
        random_phase(20);
        wait_drain();

        // back pressure: receiver holds off while bytes keep coming
        stall_long = 1'b1;
        random_phase(8);
        repeat (3000) @(posedge i_clk);
        stall_long = 1'b0;
        wait_drain();

        write_gain(CfgVoltGain, 32'h0);
        write_gain(CfgCurrGain, 32'h0);
        write_gain(CfgPwrGain, 32'h0);
        random_phase(10);
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_gain(CfgVoltGain, $urandom);
            write_gain(CfgCurrGain, $urandom);
            write_gain(CfgPwrGain, $urandom);
            random_phase(8);
            wait_drain();
        end

        if (mismatches == 0 && results_due.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hdl/pmfd_pkg.sv
hdl/pmfd_muldiv.sv
hdl/power_meter_frame_decoder.sv
dv/testbench.sv
